@@ src/differential_drive_pd_sync_assert.svh @@
// Assertion macros used by the checker file of the drive synchronizer.
`ifndef DIFFERENTIAL_DRIVE_PD_SYNC_ASSERT_SVH
`define DIFFERENTIAL_DRIVE_PD_SYNC_ASSERT_SVH

// Clocked assertion that is switched off while reset is held.
`define DDPDS_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Clocked assertion that is checked during reset as well.
`define DDPDS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ src/ddpds_pkg.sv @@
package ddpds_pkg;

    localparam int unsigned DIV_BASE   = 100;
    localparam int unsigned REM_W      = $clog2(DIV_BASE);
    localparam int unsigned GAIN_W     = 10;
    localparam int unsigned LIMIT_W    = 15;
    localparam int unsigned DRIVE_W    = 16;
    localparam int unsigned TICK_W     = 17;
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 15;
    localparam int unsigned OUT_W      = ((2 * DRIVE_W + TICK_W + 7) / 8) * 8;
    localparam int unsigned PIPE_DEPTH = 5;

    localparam logic [GAIN_W-1:0]  GAIN_P_STRAIGHT_RST = 10'd40;
    localparam logic [GAIN_W-1:0]  GAIN_D_STRAIGHT_RST = 10'd40;
    localparam logic [GAIN_W-1:0]  GAIN_P_TURN_RST     = 10'd150;
    localparam logic [GAIN_W-1:0]  GAIN_D_TURN_RST     = 10'd15;
    localparam logic [LIMIT_W-1:0] DRIVE_LIMIT_RST     = 15'd400;

    localparam logic       KIND_START = 1'b0;
    localparam logic [1:0] DIR_RIGHT  = 2'b01;
    localparam logic [1:0] DIR_LEFT   = 2'b11;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_GAIN_P_STRAIGHT = 3'd0,
        CFG_GAIN_D_STRAIGHT = 3'd1,
        CFG_GAIN_P_TURN     = 3'd2,
        CFG_GAIN_D_TURN     = 3'd3,
        CFG_DRIVE_LIMIT     = 3'd4
    } t_cfg_idx;

    // What travels beside the arithmetic from stage to stage.
    typedef struct packed {
        logic                      kind;
        logic                      turn;
        logic                      dir_pos;
        logic signed [DRIVE_W-1:0] start_right;
        logic signed [DRIVE_W-1:0] start_left;
    } t_item;

endpackage

@@ src/ddpds_err.sv @@
module ddpds_err #(
    parameter int COUNT_WIDTH = 16,
    localparam int ERR_W = COUNT_WIDTH + 1,
    localparam int RATE_W = COUNT_WIDTH + 2
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_en,
    input  logic                     i_kind,
    input  logic [COUNT_WIDTH-1:0]   i_right_count,
    input  logic [COUNT_WIDTH-1:0]   i_left_count,
    output logic signed [ERR_W-1:0]  o_err,
    output logic signed [RATE_W-1:0] o_rate
);
    import ddpds_pkg::*;

    logic [COUNT_WIDTH-1:0]   r_prev_right, r_prev_left, n_prev_right, n_prev_left;
    logic signed [ERR_W-1:0]  r_prev_err, n_prev_err;
    logic [COUNT_WIDTH-1:0]   w_dr, w_dl;
    logic signed [ERR_W-1:0]  r_err, n_err;
    logic signed [RATE_W-1:0] r_rate, n_rate;

    always_comb begin
        // Deltas wrap with the counter width, so each is a plain unsigned difference.
        w_dr = i_right_count - r_prev_right;
        w_dl = i_left_count - r_prev_left;
        if (i_kind == KIND_START) begin
            n_err        = '0;
            n_rate       = '0;
            n_prev_right = '0;
            n_prev_left  = '0;
            n_prev_err   = '0;
        end else begin
            n_err        = signed'({1'b0, w_dl}) - signed'({1'b0, w_dr});
            n_rate       = RATE_W'(n_err) - RATE_W'(r_prev_err);
            n_prev_right = i_right_count;
            n_prev_left  = i_left_count;
            n_prev_err   = n_err;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_right <= '0;
            r_prev_left  <= '0;
            r_prev_err   <= '0;
        end else if (i_en) begin
            r_prev_right <= n_prev_right;
            r_prev_left  <= n_prev_left;
            r_prev_err   <= n_prev_err;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_err  <= n_err;
            r_rate <= n_rate;
        end
    end

    assign o_err  = r_err;
    assign o_rate = r_rate;

endmodule

@@ src/ddpds_cdiv.sv @@
module ddpds_cdiv #(
    parameter int SUM_W = 30
) (
    input  logic                    i_clk,
    input  logic                    i_en_a,
    input  logic                    i_en_b,
    input  logic signed [SUM_W-1:0] i_sum,
    output logic signed [SUM_W-1:0] o_adj
);
    import ddpds_pkg::*;

    // The magnitude is split in two halves. The upper half is divided first and its
    // remainder, placed above the lower half, is divided in the second step.
    localparam int H    = SUM_W / 2;
    localparam int HI_W = SUM_W - H;
    localparam int LO_W = H + REM_W;
    localparam int QA_W = HI_W + 1 - REM_W;
    localparam int S1   = HI_W + REM_W;
    localparam int S2   = LO_W + REM_W;
    localparam int PW1  = 2 * HI_W + 1;
    localparam int PW2  = 2 * LO_W + 1;
    localparam logic [63:0] M1_FULL = ((64'd1 << S1) + 64'(DIV_BASE - 1)) / 64'(DIV_BASE);
    localparam logic [63:0] M2_FULL = ((64'd1 << S2) + 64'(DIV_BASE - 1)) / 64'(DIV_BASE);
    localparam logic [HI_W:0] M1 = M1_FULL[HI_W:0];
    localparam logic [LO_W:0] M2 = M2_FULL[LO_W:0];

    logic                    w_neg;
    logic [SUM_W-1:0]        w_mag;
    logic [HI_W-1:0]         w_hi;
    logic [H-1:0]            w_lo;
    logic [PW1-1:0]          w_prod1;
    logic [QA_W-1:0]         w_qa;
    logic                    r_neg;
    logic [QA_W-1:0]         r_qa;
    logic [HI_W-1:0]         r_hi;
    logic [H-1:0]            r_lo;
    logic [HI_W-1:0]         w_rem_full;
    logic [LO_W-1:0]         w_y;
    logic [PW2-1:0]          w_prod2;
    logic [H:0]              w_q2;
    logic [QA_W+H-1:0]       w_q;
    logic signed [SUM_W-1:0] w_qs, n_adj, r_adj;

    assign w_neg   = i_sum[SUM_W-1];
    assign w_mag   = w_neg ? SUM_W'(-i_sum) : SUM_W'(i_sum);
    assign w_hi    = w_mag[SUM_W-1:H];
    assign w_lo    = w_mag[H-1:0];
    assign w_prod1 = PW1'(w_hi) * PW1'(M1);
    assign w_qa    = w_prod1[PW1-1:S1];

    always_ff @(posedge i_clk) begin
        if (i_en_a) begin
            r_neg <= w_neg;
            r_qa  <= w_qa;
            r_hi  <= w_hi;
            r_lo  <= w_lo;
        end
    end

    assign w_rem_full = r_hi - HI_W'(r_qa) * HI_W'(DIV_BASE);
    assign w_y        = {w_rem_full[REM_W-1:0], r_lo};
    assign w_prod2    = PW2'(w_y) * PW2'(M2);
    assign w_q2       = w_prod2[PW2-1:S2];
    assign w_q        = {r_qa, w_q2[H-1:0]};
    assign w_qs       = signed'(SUM_W'(w_q));
    // Truncation toward zero: divide the magnitude, then restore the sign.
    assign n_adj      = r_neg ? -w_qs : w_qs;

    always_ff @(posedge i_clk) begin
        if (i_en_b) begin
            r_adj <= n_adj;
        end
    end

    assign o_adj = r_adj;

endmodule

@@ src/ddpds_drive.sv @@
module ddpds_drive #(
    parameter int SUM_W = 30,
    parameter int ERR_W = 17
) (
    input  logic                                       i_clk,
    input  logic                                       i_rst_n,
    input  logic                                       i_en,
    input  ddpds_pkg::t_item                           i_item,
    input  logic signed [SUM_W-1:0]                    i_adj,
    input  logic signed [ERR_W-1:0]                    i_err,
    input  logic [ddpds_pkg::LIMIT_W-1:0]              i_limit,
    output logic signed [ddpds_pkg::DRIVE_W-1:0]       o_right_drive,
    output logic signed [ddpds_pkg::DRIVE_W-1:0]       o_left_drive,
    output logic [ddpds_pkg::TICK_W-1:0]               o_tick_error
);
    import ddpds_pkg::*;

    localparam int W = SUM_W + 2;
    localparam logic signed [W-1:0] DMAX = W'(signed'({1'b0, {(DRIVE_W-1){1'b1}}}));
    localparam logic signed [W-1:0] DMIN = W'(signed'({1'b1, {(DRIVE_W-1){1'b0}}}));

    function automatic logic signed [DRIVE_W-1:0] sat_drive(input logic signed [W-1:0] v);
        logic signed [W-1:0] t;
        t = v;
        if (t > DMAX) begin
            t = DMAX;
        end else if (t < DMIN) begin
            t = DMIN;
        end
        return t[DRIVE_W-1:0];
    endfunction

    logic signed [DRIVE_W-1:0]     r_right, r_left, n_right, n_left;
    logic [TICK_W-1:0]             r_tick;
    logic signed [W-1:0]           w_adj, w_r, w_l, w_lim, w_step, w_nr, w_nl;
    logic [ERR_W+TICK_W-1:0]       w_err_ext;

    always_comb begin
        w_adj  = W'(i_adj);
        w_r    = W'(r_right);
        w_l    = W'(r_left);
        w_lim  = W'(signed'({1'b0, i_limit}));
        w_step = i_item.dir_pos ? -w_adj : w_adj;
        if (i_item.turn) begin
            // Both wheels move the same way, against the sign of the direction.
            w_nr = w_r + w_step;
            w_nl = w_l + w_step;
        end else begin
            w_nr = w_r + w_adj;
            w_nl = w_l - w_adj;
            if (w_nr > w_lim) begin
                w_nr = w_lim;
            end
            if (w_nl > w_lim) begin
                w_nl = w_lim;
            end
        end
        if (i_item.kind == KIND_START) begin
            n_right = i_item.start_right;
            n_left  = i_item.start_left;
        end else begin
            n_right = sat_drive(w_nr);
            n_left  = sat_drive(w_nl);
        end
    end

    assign w_err_ext = {{TICK_W{i_err[ERR_W-1]}}, i_err};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_right <= '0;
            r_left  <= '0;
        end else if (i_en) begin
            r_right <= n_right;
            r_left  <= n_left;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_tick <= w_err_ext[TICK_W-1:0];
        end
    end

    assign o_right_drive = r_right;
    assign o_left_drive  = r_left;
    assign o_tick_error  = r_tick;

endmodule

@@ src/differential_drive_pd_sync.sv @@
// Wheel speed synchronizer for a two-wheel differential drive (PD loop).
// Input stream: one beat per command. tuser = 0 is a start beat that loads both
// drives from tdata and clears the stored encoder counts and the last error;
// tuser = 1 is a control sample carrying both encoder counts and the direction.
// Output stream: exactly one beat per input beat, in order, carrying the new right
// and left drives and the tick error of that sample (zero for a start beat).
// Configuration: a write channel (index, data) that is always ready; gains and the
// drive limit should only be changed while no beats are in flight.
// A beat's result shows on m_axis once every stage has registered it.
// Throughput: one beat per cycle while m_axis_tready does not hold the output.
// The five-stage pipeline (error, gain multiply, two halves of the divide by 100,
// drive update) closes its state loops on the stored counts and last error in
// the first stage and on the drive registers in the last, a single add, clamp
// and saturate. Reset: drives, stored counts and last error go to zero, the
// gains and limit go to their defaults and the pipeline empties.
// Stall: when m_axis_tready is low the stages keep filling behind the held result,
// and s_axis_tready falls only once all five stages hold a beat.
module differential_drive_pd_sync #(
    parameter int COUNT_WIDTH = 16,
    localparam int IN_W = ((2 * COUNT_WIDTH + 2 + 2 * ddpds_pkg::DRIVE_W + 7) / 8) * 8
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // direction, right_count, left_count, start_right, start_left, zero fill
    input  logic [IN_W-1:0]                     s_axis_tdata,
    // kind
    input  logic                                s_axis_tuser,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // right_drive, left_drive, tick_error, zero fill
    output logic [ddpds_pkg::OUT_W-1:0]         m_axis_tdata,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [ddpds_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [ddpds_pkg::CFG_DATA_W-1:0]    i_cfg_data
);
    import ddpds_pkg::*;

    localparam int ERR_W  = COUNT_WIDTH + 1;
    localparam int RATE_W = COUNT_WIDTH + 2;
    localparam int SUM_W  = COUNT_WIDTH + 14;
    localparam int RC_LSB = 2;
    localparam int LC_LSB = RC_LSB + COUNT_WIDTH;
    localparam int SR_LSB = LC_LSB + COUNT_WIDTH;
    localparam int SL_LSB = SR_LSB + DRIVE_W;
    localparam int PAD_W  = OUT_W - 2 * DRIVE_W - TICK_W;

    // Configuration registers. The port never pushes back.
    logic [GAIN_W-1:0]  r_gp_str, r_gd_str, r_gp_turn, r_gd_turn;
    logic [LIMIT_W-1:0] r_limit;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gp_str  <= GAIN_P_STRAIGHT_RST;
            r_gd_str  <= GAIN_D_STRAIGHT_RST;
            r_gp_turn <= GAIN_P_TURN_RST;
            r_gd_turn <= GAIN_D_TURN_RST;
            r_limit   <= DRIVE_LIMIT_RST;
        end else if (i_cfg_valid) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_GAIN_P_STRAIGHT: r_gp_str  <= i_cfg_data[GAIN_W-1:0];
                CFG_GAIN_D_STRAIGHT: r_gd_str  <= i_cfg_data[GAIN_W-1:0];
                CFG_GAIN_P_TURN:     r_gp_turn <= i_cfg_data[GAIN_W-1:0];
                CFG_GAIN_D_TURN:     r_gd_turn <= i_cfg_data[GAIN_W-1:0];
                CFG_DRIVE_LIMIT:     r_limit   <= i_cfg_data[LIMIT_W-1:0];
                default: ;
            endcase
        end
    end

    // Pipeline flow control. A stage takes a new beat when it is empty or when the
    // stage after it moves on at the same edge.
    logic [PIPE_DEPTH-1:0] r_vld, w_adv, w_vin, w_load;

    always_comb begin
        w_vin = {r_vld[PIPE_DEPTH-2:0], s_axis_tvalid};
        w_adv[PIPE_DEPTH-1] = !r_vld[PIPE_DEPTH-1] || m_axis_tready;
        for (int i = PIPE_DEPTH - 2; i >= 0; i--) begin
            w_adv[i] = !r_vld[i] || w_adv[i+1];
        end
        w_load = w_adv & w_vin;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= (r_vld & ~w_adv) | (w_vin & w_adv);
        end
    end

    assign s_axis_tready = w_adv[0];
    assign m_axis_tvalid = r_vld[PIPE_DEPTH-1];

    // Side information of each beat, one entry per stage ahead of the last.
    t_item n_item;
    t_item r_item [PIPE_DEPTH-1];

    always_comb begin
        n_item.kind        = s_axis_tuser;
        n_item.turn        = (s_axis_tdata[1:0] == DIR_RIGHT) || (s_axis_tdata[1:0] == DIR_LEFT);
        n_item.dir_pos     = (s_axis_tdata[1:0] == DIR_RIGHT);
        n_item.start_right = s_axis_tdata[SR_LSB +: DRIVE_W];
        n_item.start_left  = s_axis_tdata[SL_LSB +: DRIVE_W];
    end

    always_ff @(posedge i_clk) begin
        if (w_load[0]) begin
            r_item[0] <= n_item;
        end
        for (int i = 1; i < PIPE_DEPTH - 1; i++) begin
            if (w_load[i]) begin
                r_item[i] <= r_item[i-1];
            end
        end
    end

    // Stage 1: tick deltas, error and error change.
    logic signed [ERR_W-1:0]  w_err1;
    logic signed [RATE_W-1:0] w_rate1;

    ddpds_err #(
        .COUNT_WIDTH(COUNT_WIDTH)
    ) u_err (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_en          (w_load[0]),
        .i_kind        (s_axis_tuser),
        .i_right_count (s_axis_tdata[RC_LSB +: COUNT_WIDTH]),
        .i_left_count  (s_axis_tdata[LC_LSB +: COUNT_WIDTH]),
        .o_err         (w_err1),
        .o_rate        (w_rate1)
    );

    // Stage 2: the two gain products, gains picked by the mode of the beat.
    logic signed [GAIN_W:0]   w_kp, w_kd;
    logic signed [SUM_W-1:0]  r_p, r_d, w_sum;
    logic signed [ERR_W-1:0]  r_err2, r_err3, r_err4;

    assign w_kp = signed'({1'b0, r_item[0].turn ? r_gp_turn : r_gp_str});
    assign w_kd = signed'({1'b0, r_item[0].turn ? r_gd_turn : r_gd_str});

    always_ff @(posedge i_clk) begin
        if (w_load[1]) begin
            r_p    <= SUM_W'(w_kp) * SUM_W'(w_err1);
            r_d    <= SUM_W'(w_kd) * SUM_W'(w_rate1);
            r_err2 <= w_err1;
        end
        if (w_load[2]) begin
            r_err3 <= r_err2;
        end
        if (w_load[3]) begin
            r_err4 <= r_err3;
        end
    end

    // Stages 3 and 4: sum of the products divided by 100, rounded toward zero.
    logic signed [SUM_W-1:0] w_adj;

    assign w_sum = r_p + r_d;

    ddpds_cdiv #(
        .SUM_W(SUM_W)
    ) u_cdiv (
        .i_clk  (i_clk),
        .i_en_a (w_load[2]),
        .i_en_b (w_load[3]),
        .i_sum  (w_sum),
        .o_adj  (w_adj)
    );

    // Stage 5: drive update; its registers are also the output register.
    logic signed [DRIVE_W-1:0] w_right, w_left;
    logic [TICK_W-1:0]         w_tick;

    ddpds_drive #(
        .SUM_W(SUM_W),
        .ERR_W(ERR_W)
    ) u_drive (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_en          (w_load[PIPE_DEPTH-1]),
        .i_item        (r_item[PIPE_DEPTH-2]),
        .i_adj         (w_adj),
        .i_err         (r_err4),
        .i_limit       (r_limit),
        .o_right_drive (w_right),
        .o_left_drive  (w_left),
        .o_tick_error  (w_tick)
    );

    assign m_axis_tdata = {{PAD_W{1'b0}}, w_tick, w_left, w_right};

endmodule

@@ src/ddpds_chk.sv @@
`include "differential_drive_pd_sync_assert.svh"

module ddpds_chk (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        i_s_tvalid,
    input logic                        i_s_tready,
    input logic                        i_m_tvalid,
    input logic                        i_m_tready,
    input logic [ddpds_pkg::OUT_W-1:0] i_m_tdata
);
    import ddpds_pkg::*;

    localparam int CNT_W = $clog2(PIPE_DEPTH + 1);

    logic [CNT_W-1:0] r_inflight, n_inflight;

    // Beats taken in but not yet delivered.
    assign n_inflight = r_inflight + CNT_W'(i_s_tvalid && i_s_tready)
                        - CNT_W'(i_m_tvalid && i_m_tready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inflight <= '0;
        end else begin
            r_inflight <= n_inflight;
        end
    end

    `DDPDS_ASSERT(a_out_hold, i_clk, i_rst_n, i_m_tvalid && !i_m_tready |=> i_m_tvalid && $stable(i_m_tdata), "result beat changed while stalled")
    `DDPDS_ASSERT_ALWAYS(a_rst_empty, i_clk, !i_rst_n |=> !i_m_tvalid, "result valid right after reset")
    `DDPDS_ASSERT(a_ready_only_on_stall, i_clk, i_rst_n, !i_s_tready |-> i_m_tvalid && !i_m_tready, "input blocked without an output stall")
    `DDPDS_ASSERT(a_no_phantom, i_clk, i_rst_n, i_m_tvalid |-> r_inflight != '0, "result without an accepted beat")
    `DDPDS_ASSERT(a_depth, i_clk, i_rst_n, r_inflight <= CNT_W'(PIPE_DEPTH), "more beats in flight than stages")

endmodule

bind differential_drive_pd_sync ddpds_chk u_ddpds_chk (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (s_axis_tvalid),
    .i_s_tready (s_axis_tready),
    .i_m_tvalid (m_axis_tvalid),
    .i_m_tready (m_axis_tready),
    .i_m_tdata  (m_axis_tdata)
);
